// ----- hw/rtl/olid_pkg.sv -----
// Shared types, sizes and codes for the ordered list block.
// Used by every module under hw/rtl; depends on nothing else.
package olid_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int MODE_W  = 3;
    localparam int POS_W   = 6;
    localparam int STAT_W  = 3;
    localparam int FIDX_W  = 6;
    localparam int ECNT_W  = 7;
    // common width for comparing and resizing counts and indexes
    localparam int EXT_W   = (CNT_W > ECNT_W) ? CNT_W : ECNT_W;

    localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_AT    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_BACK  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DEL_AT    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_FIND      = 3'd6;
    localparam logic [MODE_W-1:0] MODE_READ      = 3'd7;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                     strobe; // a word is accepted this cycle
        logic                     ins;    // open a gap at ptr
        logic                     del;    // close the gap at ptr
        logic [IDX_W-1:0]         ptr;
        logic signed [DATA_W-1:0] value;  // insert or search value
        logic [CNT_W-1:0]         cnt;    // count before the operation
        logic [IDX_W-1:0]         rpos;   // read position
    } t_cell_ctrl;

endpackage

// ----- hw/rtl/olid_cell.sv -----
// One list entry of the cell chain: shifts left or right, loads, compares.
// Depends on olid_pkg.
module olid_cell (
    input  logic                              i_clk,
    input  olid_pkg::t_cell_ctrl              i_ctrl,
    input  logic [olid_pkg::IDX_W-1:0]        i_index,
    input  logic signed [olid_pkg::DATA_W-1:0] i_left,
    input  logic signed [olid_pkg::DATA_W-1:0] i_right,
    output logic signed [olid_pkg::DATA_W-1:0] o_data,
    output logic                              o_match,
    output logic signed [olid_pkg::DATA_W-1:0] o_rd
);
    import olid_pkg::*;

    logic signed [DATA_W-1:0] r_data, n_data;
    logic                     r_match, n_match;
    logic                     r_sel, n_sel;
    logic [CNT_W-1:0]         index_c;

    assign index_c = CNT_W'(i_index);

    // pick the next entry: load, take from a neighbor or hold
    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins) begin
            if (i_index == i_ctrl.ptr) begin
                n_data = i_ctrl.value;
            end else if (i_index > i_ctrl.ptr) begin
                n_data = i_left;
            end
        end else if (i_ctrl.del) begin
            if (i_index >= i_ctrl.ptr) begin
                n_data = i_right;
            end
        end
    end

    // compare against the search value and the read position
    always_comb begin
        n_match = r_match;
        n_sel   = r_sel;
        if (i_ctrl.strobe) begin
            n_match = (r_data == i_ctrl.value) && (index_c < i_ctrl.cnt);
            n_sel   = (i_index == i_ctrl.rpos);
        end
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= n_match;
        r_sel   <= n_sel;
    end

    assign o_data  = r_data;
    assign o_match = r_match;
    assign o_rd    = r_sel ? r_data : '0;
endmodule

// ----- hw/rtl/olid_reduce.sv -----
// Collects the cell outputs: lowest matching index and the selected entry.
// Depends on olid_pkg.
module olid_reduce (
    input  logic [olid_pkg::DEPTH-1:0]                     i_match,
    input  logic signed [olid_pkg::DEPTH-1:0][olid_pkg::DATA_W-1:0] i_rd,
    output logic                                           o_hit,
    output logic [olid_pkg::IDX_W-1:0]                     o_index,
    output logic signed [olid_pkg::DATA_W-1:0]             o_rd
);
    import olid_pkg::*;

    // priority encode, lowest index wins
    always_comb begin
        o_index = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                o_index = IDX_W'(i);
            end
        end
    end

    assign o_hit = |i_match;

    // at most one cell is selected, so an OR gives its entry
    always_comb begin
        o_rd = '0;
        for (int i = 0; i < DEPTH; i++) begin
            o_rd = o_rd | i_rd[i];
        end
    end
endmodule

// ----- hw/rtl/ordered_list_insert_delete_search_top.sv -----
// Top level of the ordered list: controller, chain of cells, output register.
// Depends on olid_pkg, olid_cell and olid_reduce.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one word with mode,
//   value and position. Output channel (o_out_valid / i_out_stall) returns
//   one word per input: status, found index, read value and element count.
//   A word is taken at an edge where valid is high and stall is low.
//   At the accepting edge every cell shifts or loads in parallel and
//   latches its compare into the compare stage; once the output register
//   is free, the lowest match and the read entry are encoded into it and
//   o_out_valid rises. One word per cycle is sustained while the receiver
//   takes results; the reduction depth over DEPTH cells sets the cycle time.
//   When the receiver stalls, the result holds in the output register and
//   one more word waits in the compare stage; after that o_in_stall rises.
//   Reset empties the list (count zero) and drops any result in flight;
//   entry contents are left as they are and are not read before written.
module ordered_list_insert_delete_search_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [olid_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [olid_pkg::DATA_W-1:0]  i_value,
    input  logic [olid_pkg::POS_W-1:0]          i_position,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [olid_pkg::STAT_W-1:0]         o_status,
    output logic [olid_pkg::FIDX_W-1:0]         o_found_index,
    output logic signed [olid_pkg::DATA_W-1:0]  o_read_value,
    output logic [olid_pkg::ECNT_W-1:0]         o_element_count
);
    import olid_pkg::*;

    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_pend;
    logic [STAT_W-1:0] r_p_status, n_status;
    logic [MODE_W-1:0] r_p_mode;
    logic [CNT_W-1:0]  r_p_count;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [FIDX_W-1:0] r_out_fidx;
    logic signed [DATA_W-1:0] r_out_rval;
    logic [ECNT_W-1:0] r_out_cnt;

    logic              accept, out_free, move;
    logic [EXT_W-1:0]  pos_e, cnt_e, ptr_e;
    logic              full, empty, is_ins, is_del, op_ok;
    t_cell_ctrl        ctrl;

    logic signed [DEPTH-1:0][DATA_W-1:0] cell_data;
    logic signed [DEPTH-1:0][DATA_W-1:0] cell_rd;
    logic [DEPTH-1:0]  cell_match;
    logic              red_hit;
    logic [IDX_W-1:0]  red_index;
    logic signed [DATA_W-1:0] red_rd;
    logic [STAT_W-1:0] fin_status;
    logic [EXT_W-1:0]  fidx_e, ocnt_e;

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign move       = r_pend && out_free;
    assign o_in_stall = r_pend && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    // decode the word against the current count
    assign pos_e = EXT_W'(i_position);
    assign cnt_e = EXT_W'(r_count);
    assign full  = (cnt_e == EXT_W'(DEPTH));
    assign empty = (r_count == '0);

    always_comb begin
        n_status = ST_OK;
        ptr_e    = '0;
        is_ins   = 1'b0;
        is_del   = 1'b0;
        case (i_mode) inside
            MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT: begin
                is_ins = 1'b1;
                if (full) begin
                    n_status = ST_FULL;
                end else if (i_mode == MODE_INS_BACK) begin
                    ptr_e = cnt_e;
                end else if (i_mode == MODE_INS_AT && !empty) begin
                    if (pos_e >= cnt_e) begin
                        n_status = ST_RANGE;
                    end else begin
                        ptr_e = pos_e;
                    end
                end
            end
            MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT: begin
                is_del = 1'b1;
                if (empty) begin
                    n_status = ST_EMPTY;
                end else if (i_mode == MODE_DEL_BACK) begin
                    ptr_e = cnt_e - EXT_W'(1);
                end else if (i_mode == MODE_DEL_AT) begin
                    if (pos_e >= cnt_e) begin
                        n_status = ST_RANGE;
                    end else begin
                        ptr_e = pos_e;
                    end
                end
            end
            MODE_FIND: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end
            end
            default: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else if (pos_e >= cnt_e) begin
                    n_status = ST_RANGE;
                end
            end
        endcase
    end

    assign op_ok = (n_status == ST_OK);

    always_comb begin
        ctrl.strobe = accept;
        ctrl.ins    = accept && is_ins && op_ok;
        ctrl.del    = accept && is_del && op_ok;
        ctrl.ptr    = ptr_e[IDX_W-1:0];
        ctrl.value  = i_value;
        ctrl.cnt    = r_count;
        ctrl.rpos   = pos_e[IDX_W-1:0];
    end

    always_comb begin
        n_count = r_count;
        if (ctrl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctrl.del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // chain of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] left_d, right_d;
        if (g == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_data[g+1];
        end
        olid_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_index (IDX_W'(g)),
            .i_left  (left_d),
            .i_right (right_d),
            .o_data  (cell_data[g]),
            .o_match (cell_match[g]),
            .o_rd    (cell_rd[g])
        );
    end

    olid_reduce u_reduce (
        .i_match (cell_match),
        .i_rd    (cell_rd),
        .o_hit   (red_hit),
        .o_index (red_index),
        .o_rd    (red_rd)
    );

    // count and compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_pend <= 1'b1;
            end else if (move) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_status <= n_status;
            r_p_mode   <= i_mode;
            r_p_count  <= n_count;
        end
    end

    // finish the word: not found, gated index and read value
    always_comb begin
        fin_status = r_p_status;
        if (r_p_mode == MODE_FIND && r_p_status == ST_OK && !red_hit) begin
            fin_status = ST_NOTFOUND;
        end
    end

    assign fidx_e = EXT_W'(red_index);
    assign ocnt_e = EXT_W'(r_p_count);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_status <= fin_status;
            r_out_fidx   <= (r_p_mode == MODE_FIND && fin_status == ST_OK)
                            ? fidx_e[FIDX_W-1:0] : '0;
            r_out_rval   <= (r_p_mode == MODE_READ && fin_status == ST_OK)
                            ? red_rd : '0;
            r_out_cnt    <= ocnt_e[ECNT_W-1:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_found_index   = r_out_fidx;
    assign o_read_value    = r_out_rval;
    assign o_element_count = r_out_cnt;

    // count never passes the depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EXT_W'(r_count) <= EXT_W'(DEPTH))
        else $error("element count above depth");

    // a good insert grows the list by one
    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.ins |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow the list");

    // a full status is only given on a full list
    a_full_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && r_p_status == ST_FULL) |-> (EXT_W'(r_p_count) == EXT_W'(DEPTH)))
        else $error("full status on a list that is not full");

    // input is only held off while a word waits behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_pend && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");
endmodule

// ----- tb/tb_ordered_list_insert_delete_search_top.sv -----
// Self-checking testbench for ordered_list_insert_delete_search_top.
// Drives list operations over a valid/stall channel and checks each result
// word against a shadow list kept here or a result typed in by hand; depends on olid_pkg and the RTL.
module tb_ordered_list_insert_delete_search_top;
    import olid_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int QUIET_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 150;
    localparam int PHASE_WORDS   = 150;
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_LIMIT  = 10;
    localparam int DIRECTED_ROWS = 25;

    // one result word as the block returns it
    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic [FIDX_W-1:0]         fidx;
        logic signed [DATA_W-1:0]  rval;
        logic [ECNT_W-1:0]         cnt;
    } list_result_t;

    // one directed row; given marks a result typed in by hand
    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [DATA_W-1:0]  value;
        logic [POS_W-1:0]          pos;
        logic                      given;
        list_result_t              want;
    } step_row_t;

    localparam list_result_t NO_WANT = '{ST_OK, '0, '0, '0};

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [MODE_W-1:0]          i_mode = MODE_READ;
    logic signed [DATA_W-1:0]   i_value = '0;
    logic [POS_W-1:0]           i_position = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [STAT_W-1:0]          o_status;
    logic [FIDX_W-1:0]          o_found_index;
    logic signed [DATA_W-1:0]   o_read_value;
    logic [ECNT_W-1:0]          o_element_count;

    logic signed [DATA_W-1:0]   shadow_list[$];
    list_result_t               pending_results[$];
    step_row_t                  directed_steps [0:DIRECTED_ROWS-1];
    int                         mismatches = 0;
    int                         idle_pct = 0;
    int                         stall_pct = 0;
    logic                       hold_go = 1'b0;
    logic                       hold_off = 1'b0;

    ordered_list_insert_delete_search_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_value         (i_value),
        .i_position      (i_position),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_found_index   (o_found_index),
        .o_read_value    (o_read_value),
        .o_element_count (o_element_count)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Apply one operation to the shadow list and return the word it yields.
    function automatic list_result_t apply_list_op(input logic [MODE_W-1:0] mode,
                                                   input logic signed [DATA_W-1:0] value,
                                                   input logic [POS_W-1:0] pos);
        list_result_t r;
        int           n;
        int           at;
        r  = NO_WANT;
        n  = shadow_list.size();
        at = int'(pos);
        case (mode)
            MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT: begin
                if (n >= DEPTH)
                    r.status = ST_FULL;
                else if (mode == MODE_INS_FRONT)
                    shadow_list.push_front(value);
                else if (mode == MODE_INS_BACK || n == 0)
                    shadow_list.push_back(value);
                else if (at >= n)
                    r.status = ST_RANGE;
                else
                    shadow_list.insert(at, value);
            end
            MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT: begin
                if (n == 0)
                    r.status = ST_EMPTY;
                else if (mode == MODE_DEL_FRONT)
                    shadow_list.delete(0);
                else if (mode == MODE_DEL_BACK)
                    shadow_list.delete(n - 1);
                else if (at >= n)
                    r.status = ST_RANGE;
                else
                    shadow_list.delete(at);
            end
            MODE_FIND: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // scan downward so the lowest hit wins
                    r.status = ST_NOTFOUND;
                    for (int i = n - 1; i >= 0; i--) begin
                        if (shadow_list[i] == value) begin
                            r.status = ST_OK;
                            r.fidx   = FIDX_W'(i);
                        end
                    end
                end
            end
            default: begin
                if (n == 0)
                    r.status = ST_EMPTY;
                else if (at >= n)
                    r.status = ST_RANGE;
                else
                    r.rval = shadow_list[at];
            end
        endcase
        r.cnt = ECNT_W'(shadow_list.size());
        return r;
    endfunction

    // Offer one word, hold it until taken, then queue its expected result.
    task automatic offer_word(input logic [MODE_W-1:0] mode,
                              input logic signed [DATA_W-1:0] value,
                              input logic [POS_W-1:0] pos,
                              input logic given,
                              input list_result_t want);
        list_result_t predicted;
        if ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_value    <= value;
        i_position <= pos;
        do @(posedge i_clk); while (o_in_stall);
        predicted = apply_list_op(mode, value, pos);
        pending_results.push_back(given ? want : predicted);
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
    endtask

    // Randomly stall the result channel; hold it off entirely on request.
    always @(posedge i_clk) begin
        i_out_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
    end

    initial begin : receiver_hold
        wait (hold_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Compare every accepted result word with the oldest expectation.
    always @(posedge i_clk) begin
        list_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result word with none expected: status %0d count %0d",
                             o_status, o_element_count);
            end else begin
                want = pending_results.pop_front();
                check_field("status", DATA_W'(want.status), DATA_W'(o_status));
                check_field("found_index", DATA_W'(want.fidx), DATA_W'(o_found_index));
                check_field("read_value", want.rval, o_read_value);
                check_field("element_count", DATA_W'(want.cnt), DATA_W'(o_element_count));
            end
        end
    end

    // End the run when neither channel moves for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("ordered_list_insert_delete_search_top regression: fail");
        $finish;
    end

    initial begin : stimulus
        logic signed [DATA_W-1:0] value_pool [0:7];
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         pos;
        int                       n;
        int                       roll;
        int                       edge_tries;
        bit                       growing;

        value_pool = '{32'sh0000_0000, 32'shFFFF_FFFF, 32'sh0000_0001, 32'sh8000_0000,
                       32'sh7FFF_FFFF, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh1234_5678};

        directed_steps = '{
            // empty list: every delete, find and read is flagged
            '{MODE_DEL_FRONT, 32'sh0,         6'd0,  1'b1, '{ST_EMPTY, 6'd0, 32'sh0, 7'd0}},
            '{MODE_DEL_BACK,  32'sh0,         6'd0,  1'b1, '{ST_EMPTY, 6'd0, 32'sh0, 7'd0}},
            '{MODE_DEL_AT,    32'sh0,         6'd0,  1'b1, '{ST_EMPTY, 6'd0, 32'sh0, 7'd0}},
            '{MODE_FIND,      32'sh0,         6'd0,  1'b1, '{ST_EMPTY, 6'd0, 32'sh0, 7'd0}},
            '{MODE_READ,      32'sh0,         6'd0,  1'b1, '{ST_EMPTY, 6'd0, 32'sh0, 7'd0}},
            // insert at into an empty list lands at index zero
            '{MODE_INS_AT,    32'sh7FFF_FFFF, 6'd63, 1'b1, '{ST_OK, 6'd0, 32'sh0, 7'd1}},
            '{MODE_READ,      32'sh0,         6'd0,  1'b1,
              '{ST_OK, 6'd0, 32'sh7FFF_FFFF, 7'd1}},
            '{MODE_READ,      32'sh0,         6'd63, 1'b1, '{ST_RANGE, 6'd0, 32'sh0, 7'd1}},
            '{MODE_INS_FRONT, 32'sh8000_0000, 6'd0,  1'b1, '{ST_OK, 6'd0, 32'sh0, 7'd2}},
            '{MODE_INS_BACK,  32'sh0,         6'd0,  1'b1, '{ST_OK, 6'd0, 32'sh0, 7'd3}},
            // insert at the count itself is out of range
            '{MODE_INS_AT,    32'sh1,         6'd3,  1'b1, '{ST_RANGE, 6'd0, 32'sh0, 7'd3}},
            '{MODE_INS_AT,    32'shFFFF_FFFF, 6'd1,  1'b0, NO_WANT},
            '{MODE_FIND,      32'sh7FFF_FFFF, 6'd0,  1'b0, NO_WANT},
            '{MODE_FIND,      32'sh0000_3039, 6'd0,  1'b1, '{ST_NOTFOUND, 6'd0, 32'sh0, 7'd4}},
            // duplicate value: find must report the lowest index
            '{MODE_INS_BACK,  32'shFFFF_FFFF, 6'd0,  1'b0, NO_WANT},
            '{MODE_FIND,      32'shFFFF_FFFF, 6'd0,  1'b0, NO_WANT},
            '{MODE_DEL_AT,    32'sh0,         6'd5,  1'b1, '{ST_RANGE, 6'd0, 32'sh0, 7'd5}},
            '{MODE_DEL_AT,    32'sh0,         6'd1,  1'b0, NO_WANT},
            '{MODE_READ,      32'sh0,         6'd1,  1'b0, NO_WANT},
            '{MODE_DEL_FRONT, 32'sh0,         6'd0,  1'b0, NO_WANT},
            '{MODE_DEL_BACK,  32'sh0,         6'd0,  1'b0, NO_WANT},
            '{MODE_DEL_AT,    32'sh0,         6'd1,  1'b0, NO_WANT},
            // deleting the only element empties the list
            '{MODE_DEL_BACK,  32'sh0,         6'd0,  1'b1, '{ST_OK, 6'd0, 32'sh0, 7'd0}},
            '{MODE_READ,      32'sh0,         6'd0,  1'b1, '{ST_EMPTY, 6'd0, 32'sh0, 7'd0}},
            '{MODE_INS_BACK,  32'sh5A5A_5A5A, 6'd0,  1'b1, '{ST_OK, 6'd0, 32'sh0, 7'd1}}
        };

        // hold reset, then release it at an edge
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
            offer_word(directed_steps[r].mode, directed_steps[r].value,
                       directed_steps[r].pos, directed_steps[r].given,
                       directed_steps[r].want);

        // Random part: swing the list between full and empty, dwelling a
        // few words at each end so the full and empty flags are exercised.
        growing    = 1'b1;
        edge_tries = 0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  hold_go = 1'b1; end
                1: begin idle_pct = 55; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 55; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase
            for (int k = 0; k < PHASE_WORDS; k++) begin
                n = shadow_list.size();
                if ((growing && n == DEPTH) || (!growing && n == 0)) begin
                    edge_tries++;
                    if (edge_tries > 3) begin
                        growing    = !growing;
                        edge_tries = 0;
                    end
                end
                roll = $urandom_range(0, 99);
                if (roll < 55)
                    mode = growing ? MODE_W'(MODE_INS_FRONT + $urandom_range(0, 2))
                                   : MODE_W'(MODE_DEL_FRONT + $urandom_range(0, 2));
                else if (roll < 75)
                    mode = MODE_FIND;
                else if (roll < 90)
                    mode = MODE_READ;
                else
                    mode = MODE_W'($urandom_range(MODE_INS_FRONT, MODE_READ));

                if ($urandom_range(0, 1) != 0)
                    value = value_pool[$urandom_range(0, 7)];
                else
                    value = $urandom;
                // search mostly for values that are present
                if (mode == MODE_FIND && n > 0 && $urandom_range(0, 99) < 60)
                    value = shadow_list[$urandom_range(0, n - 1)];

                if (n > 0 && $urandom_range(0, 99) < 80)
                    pos = POS_W'($urandom_range(0, (n > 63) ? 63 : n));
                else
                    pos = POS_W'($urandom_range(0, 63));

                offer_word(mode, value, pos, 1'b0, NO_WANT);
            end
        end

        // drop valid and let every pending word come back
        i_in_valid <= 1'b0;
        stall_pct  = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("ordered_list_insert_delete_search_top regression: pass");
        else
            $display("ordered_list_insert_delete_search_top regression: fail");
        $finish;
    end

endmodule
